// File: rtl/rne_pkg.sv
// Shared types, symbol codes and the control store for the Roman numeral encoder.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`default_nettype none

package rne_pkg;

  // symbol codes on the output beat
  localparam logic [2:0] SYM_I = 3'd0;
  localparam logic [2:0] SYM_V = 3'd1;
  localparam logic [2:0] SYM_X = 3'd2;
  localparam logic [2:0] SYM_L = 3'd3;
  localparam logic [2:0] SYM_C = 3'd4;
  localparam logic [2:0] SYM_D = 3'd5;
  localparam logic [2:0] SYM_M = 3'd6;

  localparam int unsigned ValueW = 12;
  localparam int unsigned MultW  = 14;  // holds nine times the largest place value
  localparam int unsigned DigitW = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned PcW    = 3;

  // beat payloads
  typedef struct packed {
    logic [ValueW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] symbol;
    logic       last;
  } out_beat_t;

  // decimal position being worked on
  typedef enum logic [1:0] {
    POS_THOU = 2'd0,
    POS_HUND = 2'd1,
    POS_TENS = 2'd2,
    POS_ONES = 2'd3
  } pos_e;

  // which symbol of the position's set to emit
  typedef enum logic [1:0] {
    SEL_UNIT = 2'd0,
    SEL_FIVE = 2'd1,
    SEL_TEN  = 2'd2
  } sym_sel_e;

  // where the end-of-digit mark of an emitted symbol comes from
  typedef enum logic [1:0] {
    LS_NONE   = 2'd0,
    LS_ALWAYS = 2'd1,
    LS_CNT1   = 2'd2,
    LS_CNT0   = 2'd3
  } last_src_e;

  // next-step selection
  typedef enum logic [2:0] {
    J_WAIT     = 3'd0,
    J_NEXT     = 3'd1,
    J_DISPATCH = 3'd2,
    J_LOOP     = 3'd3,
    J_CNT      = 3'd4,
    J_END      = 3'd5
  } jump_e;

  // step addresses of the program
  localparam logic [PcW-1:0] PC_IDLE = 3'd0;
  localparam logic [PcW-1:0] PC_EXT  = 3'd1;
  localparam logic [PcW-1:0] PC_REP  = 3'd2;
  localparam logic [PcW-1:0] PC_D4A  = 3'd3;
  localparam logic [PcW-1:0] PC_D4B  = 3'd4;
  localparam logic [PcW-1:0] PC_D5   = 3'd5;
  localparam logic [PcW-1:0] PC_D9A  = 3'd6;
  localparam logic [PcW-1:0] PC_D9B  = 3'd7;

  typedef struct packed {
    logic            ext;
    logic            emit;
    sym_sel_e        sel;
    last_src_e       lsrc;
    logic            cnt_dec;
    jump_e           jump;
    logic [PcW-1:0]  target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic     load;
    logic     ext;
    logic     cnt_dec;
    logic     pos_inc;
    logic     emit;
    sym_sel_e sel;
    logic     last;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              is_thou;
    logic              is_ones;
    logic              rem_zero;
    logic              cnt_is0;
    logic              cnt_is1;
    logic              out_busy;
  } stat_t;

  // control store: one word per step
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '{ext: 1'b0, emit: 1'b0, sel: SEL_UNIT, lsrc: LS_NONE, cnt_dec: 1'b0,
          jump: J_NEXT, target: PC_IDLE};
    unique case (pc)
      PC_IDLE: w.jump = J_WAIT;
      PC_EXT: begin
        w.ext  = 1'b1;
        w.jump = J_DISPATCH;
      end
      PC_REP: begin
        w.emit    = 1'b1;
        w.lsrc    = LS_CNT1;
        w.cnt_dec = 1'b1;
        w.jump    = J_LOOP;
        w.target  = PC_REP;
      end
      PC_D4A: w.emit = 1'b1;
      PC_D4B: begin
        w.emit = 1'b1;
        w.sel  = SEL_FIVE;
        w.lsrc = LS_ALWAYS;
        w.jump = J_END;
      end
      PC_D5: begin
        w.emit   = 1'b1;
        w.sel    = SEL_FIVE;
        w.lsrc   = LS_CNT0;
        w.jump   = J_CNT;
        w.target = PC_REP;
      end
      PC_D9A: w.emit = 1'b1;
      PC_D9B: begin
        w.emit = 1'b1;
        w.sel  = SEL_TEN;
        w.lsrc = LS_ALWAYS;
        w.jump = J_END;
      end
    endcase
    return w;
  endfunction

  // place value of a position
  function automatic logic [9:0] place_val(input pos_e pos);
    logic [9:0] p;
    p = 10'd1;
    unique case (pos)
      POS_THOU: p = 10'd1000;
      POS_HUND: p = 10'd100;
      POS_TENS: p = 10'd10;
      POS_ONES: p = 10'd1;
    endcase
    return p;
  endfunction

  // digit times place value
  function automatic logic [MultW-1:0] place_mult(input pos_e pos,
                                                  input logic [DigitW-1:0] d);
    return MultW'(MultW'(d) * MultW'(place_val(pos)));
  endfunction

  // symbol code for a position and selection
  function automatic logic [2:0] sym_code(input pos_e pos, input sym_sel_e sel);
    logic [2:0] s;
    s = SYM_M;
    unique case (pos)
      POS_THOU: s = SYM_M;
      POS_HUND: begin
        unique case (sel)
          SEL_UNIT: s = SYM_C;
          SEL_FIVE: s = SYM_D;
          SEL_TEN:  s = SYM_M;
          default:  s = SYM_C;
        endcase
      end
      POS_TENS: begin
        unique case (sel)
          SEL_UNIT: s = SYM_X;
          SEL_FIVE: s = SYM_L;
          SEL_TEN:  s = SYM_C;
          default:  s = SYM_X;
        endcase
      end
      POS_ONES: begin
        unique case (sel)
          SEL_UNIT: s = SYM_I;
          SEL_FIVE: s = SYM_V;
          SEL_TEN:  s = SYM_X;
          default:  s = SYM_I;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rne_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// Payload type is given by the instantiating level; no other dependencies.
`default_nettype none

interface rne_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/rne_datapath.sv
// Datapath of the encoder: remainder, position and repeat counter, digit
// extraction by place value, and the output beat register. Uses rne_pkg.
`default_nettype none

module rne_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rne_pkg::ctrl_t                ctrl_i,
  input  logic [rne_pkg::ValueW-1:0]    value_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [2:0]                    out_sym_o,
  output logic                          out_last_o,
  output rne_pkg::stat_t                stat_o
);

  logic [rne_pkg::ValueW-1:0] rem_q, rem_d;
  rne_pkg::pos_e              pos_q, pos_d;
  logic [rne_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [2:0]                 out_sym_q, out_sym_d;
  logic                       out_last_q, out_last_d;

  logic [rne_pkg::DigitW-1:0] digit;
  logic [rne_pkg::MultW-1:0]  sub_val;

  // digit at the current position: largest multiple of the place not above rem
  always_comb begin
    digit   = '0;
    sub_val = '0;
    for (int d = 1; d <= 9; d++) begin
      if (rne_pkg::MultW'(rem_q) >= rne_pkg::place_mult(pos_q, rne_pkg::DigitW'(d))) begin
        digit   = rne_pkg::DigitW'(d);
        sub_val = rne_pkg::place_mult(pos_q, rne_pkg::DigitW'(d));
      end
    end
  end

  // working registers
  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      rem_d = value_i;
      pos_d = rne_pkg::POS_THOU;
    end else begin
      if (ctrl_i.ext) begin
        rem_d = rem_q - sub_val[rne_pkg::ValueW-1:0];
        if (digit >= rne_pkg::DigitW'(5) && pos_q != rne_pkg::POS_THOU) begin
          cnt_d = rne_pkg::CntW'(digit - rne_pkg::DigitW'(5));
        end else begin
          cnt_d = rne_pkg::CntW'(digit);
        end
      end
      if (ctrl_i.cnt_dec) begin
        cnt_d = cnt_q - rne_pkg::CntW'(1);
      end
      if (ctrl_i.pos_inc) begin
        pos_d = rne_pkg::pos_e'(2'(pos_q + 2'd1));
      end
    end
  end

  // output beat register: loads on emit, empties when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
      out_sym_d   = rne_pkg::sym_code(pos_q, ctrl_i.sel);
      out_last_d  = ctrl_i.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  // status for the sequencer
  always_comb begin
    stat_o.digit    = digit;
    stat_o.is_thou  = (pos_q == rne_pkg::POS_THOU);
    stat_o.is_ones  = (pos_q == rne_pkg::POS_ONES);
    stat_o.rem_zero = (rem_q == '0);
    stat_o.cnt_is0  = (cnt_q == '0);
    stat_o.cnt_is1  = (cnt_q == rne_pkg::CntW'(1));
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_sym_o   = out_sym_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/rne_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Uses rne_pkg; drives the datapath through rne_pkg::ctrl_t.
`default_nettype none

module rne_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rne_pkg::stat_t stat_i,
  output rne_pkg::ctrl_t ctrl_o
);

  logic [rne_pkg::PcW-1:0] pc_q, pc_d;
  rne_pkg::uword_t         w;
  logic                    stall;
  logic                    grp_last;
  logic                    grp_end;

  assign w = rne_pkg::ucode(pc_q);

  // end-of-digit mark of the symbol emitted at this step
  always_comb begin
    grp_last = 1'b0;
    unique case (w.lsrc)
      rne_pkg::LS_NONE:   grp_last = 1'b0;
      rne_pkg::LS_ALWAYS: grp_last = 1'b1;
      rne_pkg::LS_CNT1:   grp_last = stat_i.cnt_is1;
      rne_pkg::LS_CNT0:   grp_last = stat_i.cnt_is0;
    endcase
  end

  // next step and control word
  always_comb begin
    pc_d           = pc_q;
    in_ready_o     = 1'b0;
    grp_end        = 1'b0;
    stall          = w.emit && stat_i.out_busy;
    ctrl_o.load    = 1'b0;
    ctrl_o.ext     = 1'b0;
    ctrl_o.cnt_dec = 1'b0;
    ctrl_o.pos_inc = 1'b0;
    ctrl_o.emit    = 1'b0;
    ctrl_o.sel     = w.sel;
    ctrl_o.last    = grp_last && stat_i.rem_zero;

    if (w.jump == rne_pkg::J_WAIT) begin
      in_ready_o = 1'b1;
      if (in_valid_i) begin
        ctrl_o.load = 1'b1;
        pc_d        = rne_pkg::PC_EXT;
      end
    end else if (!stall) begin
      ctrl_o.ext     = w.ext;
      ctrl_o.emit    = w.emit;
      ctrl_o.cnt_dec = w.cnt_dec;
      unique case (w.jump)
        rne_pkg::J_NEXT: pc_d = pc_q + rne_pkg::PcW'(1);
        rne_pkg::J_DISPATCH: begin
          if (stat_i.digit == '0) begin
            grp_end = 1'b1;
          end else if (stat_i.is_thou || stat_i.digit < rne_pkg::DigitW'(4)) begin
            pc_d = rne_pkg::PC_REP;
          end else if (stat_i.digit == rne_pkg::DigitW'(4)) begin
            pc_d = rne_pkg::PC_D4A;
          end else if (stat_i.digit < rne_pkg::DigitW'(9)) begin
            pc_d = rne_pkg::PC_D5;
          end else begin
            pc_d = rne_pkg::PC_D9A;
          end
        end
        rne_pkg::J_LOOP: begin
          if (!stat_i.cnt_is1) begin
            pc_d = w.target;
          end else begin
            grp_end = 1'b1;
          end
        end
        rne_pkg::J_CNT: begin
          if (!stat_i.cnt_is0) begin
            pc_d = w.target;
          end else begin
            grp_end = 1'b1;
          end
        end
        rne_pkg::J_END: grp_end = 1'b1;
        default:        pc_d = rne_pkg::PC_IDLE;
      endcase

      // digit done: finish the value or move to the next position
      if (grp_end) begin
        if (stat_i.is_ones || stat_i.rem_zero) begin
          pc_d = rne_pkg::PC_IDLE;
        end else begin
          ctrl_o.pos_inc = 1'b1;
          pc_d           = rne_pkg::PC_EXT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= rne_pkg::PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/roman_numeral_encoder_core.sv
// Top level of the Roman numeral encoder: sequencer plus datapath.
// Depends on rne_pkg, rne_stream_if, rne_sequencer and rne_datapath.
//
//   channel  dir  modport  payload              one beat
//   in_i     in   sink     value[11:0]          one number to convert
//   out_o    out  source   symbol[2:0], last    one numeral symbol
//
// A value is taken in the idle step, then per decimal position one extraction
// step follows, then one step per symbol; positions after the last nonzero
// one are skipped. Reset clears the step counter and the output valid flag.
// A stalled output holds the sequencer on its emit step only.
`default_nettype none

module roman_numeral_encoder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  rne_stream_if.sink   in_i,
  rne_stream_if.source out_o
);

  rne_pkg::ctrl_t ctrl;
  rne_pkg::stat_t stat;
  logic           out_valid;
  logic [2:0]     out_sym;
  logic           out_last;

  rne_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rne_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .value_i     (in_i.payload.value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_sym_o   (out_sym),
    .out_last_o  (out_last),
    .stat_o      (stat)
  );

  // output beat
  assign out_o.valid          = out_valid;
  assign out_o.payload.symbol = out_sym;
  assign out_o.payload.last   = out_last;

endmodule

`default_nettype wire
